FILE: design/pcil_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pcil_pkg
// Shared types and constants for the path constraint interval lookup.
// ---------------------------------------------------------------------------
package pcil_pkg;

    localparam int SPEED_DEPTH_DEF   = 16;
    localparam int HEADING_DEPTH_DEF = 16;

    localparam int POS_W     = 32;   // Q16.16 position
    localparam int VAL_W     = 32;   // Q16.16 limit value
    localparam int GAP_W     = 16;   // min_gap register
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATH_READY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP    = 2'd1;

    typedef enum logic [1:0] {
        REQ_INS_SPD = 2'd0,
        REQ_INS_HDG = 2'd1,
        REQ_QUERY   = 2'd2,
        REQ_CLEAR   = 2'd3
    } t_req;

    typedef struct packed {
        logic [1:0]              req_type;
        logic signed [POS_W-1:0] position;
        logic signed [VAL_W-1:0] speed_limit;
        logic signed [VAL_W-1:0] accel_limit;
        logic signed [VAL_W-1:0] jerk_limit;
        logic signed [VAL_W-1:0] heading;
        logic signed [VAL_W-1:0] turn_rate_limit;
        logic signed [VAL_W-1:0] turn_accel_limit;
        logic                    tangent_heading;
    } t_in_item;

    typedef struct packed {
        logic                    accepted;
        logic                    speed_valid;
        logic                    heading_valid;
        logic signed [VAL_W-1:0] out_speed;
        logic signed [VAL_W-1:0] out_accel;
        logic signed [VAL_W-1:0] out_jerk;
        logic signed [VAL_W-1:0] out_heading;
        logic signed [VAL_W-1:0] out_turn_rate;
        logic signed [VAL_W-1:0] out_turn_accel;
        logic                    out_tangent;
    } t_out_item;

    // table entries as stored in RAM
    typedef struct packed {
        logic signed [POS_W-1:0] pos;
        logic signed [VAL_W-1:0] speed;
        logic signed [VAL_W-1:0] accel;
        logic signed [VAL_W-1:0] jerk;
    } t_spd_ent;

    typedef struct packed {
        logic signed [POS_W-1:0] pos;
        logic signed [VAL_W-1:0] heading;
        logic signed [VAL_W-1:0] turn_rate;
        logic signed [VAL_W-1:0] turn_accel;
        logic                    tangent;
    } t_hdg_ent;

    // read address relative to the cursor
    typedef enum logic [1:0] {
        RD_CUR = 2'd0,
        RD_DEC = 2'd1,
        RD_INC = 2'd2
    } t_rd_sel;

    typedef enum logic [2:0] {
        CUR_HOLD  = 3'd0,
        CUR_DEC   = 3'd1,
        CUR_INC   = 3'd2,
        CUR_CLAMP = 3'd3
    } t_cur_op;

    typedef struct packed {
        logic    tbl;      // 0 speed table, 1 heading table
        t_rd_sel rd_sel;
        t_cur_op cur_op;
        logic    load;     // latch input item, clear working result
        logic    ins;
        logic    clr;
        logic    cap;      // copy read entry into working result
        logic    ld_out;   // working result -> output register
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic path_ready;
        logic empty;       // selected table has no entries
        logic at_first;    // selected cursor is 0
        logic at_last;     // selected cursor is count-1
        logic gt;          // query position > read position
        logic lt;          // query position < read position
        logic gt_right;    // query position > saved right bound
        logic neg;         // query position below zero
    } t_status;

endpackage : pcil_pkg
`default_nettype wire

FILE: design/path_constraint_interval_lookup.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// path_constraint_interval_lookup
// Two breakpoint tables (speed limits, heading limits) along a path with
// gap-checked append, clear, and cursor-walk interval lookup.
// ---------------------------------------------------------------------------
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  ----------------------------
//  in       sink       i_valid / o_stall         i_in_item  (t_in_item)
//  out      source     o_valid / i_stall         o_out_item (t_out_item)
//  cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  Insert and clear pass through the EXEC and DONE steps from transfer to result.
//  A query walks each table's cursor one entry at a time through a
//  single-read-port RAM, starting from the cursors kept from the last query.
//  One item is in work at a time; the next transfer is taken once the result
//  has moved into the output register, even while that register is stalled.
//  Synchronous active-low reset empties both tables and zeroes the cursors;
//  path_ready resets to 0 and min_gap to 1. No clearing pass is needed.
//  Config writes are always ready and should only be issued while idle.
// ---------------------------------------------------------------------------
module path_constraint_interval_lookup #(
    parameter int SPEED_DEPTH   = pcil_pkg::SPEED_DEPTH_DEF,
    parameter int HEADING_DEPTH = pcil_pkg::HEADING_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // request channel
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire pcil_pkg::t_in_item             i_in_item,
    // result channel
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output pcil_pkg::t_out_item                 o_out_item,
    // register write channel
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [pcil_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [pcil_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import pcil_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // registers accept a write in any cycle
    assign o_cfg_ready = 1'b1;

    pcil_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    pcil_dpath #(
        .SPEED_DEPTH   (SPEED_DEPTH),
        .HEADING_DEPTH (HEADING_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_item  (o_out_item)
    );

endmodule : path_constraint_interval_lookup
`default_nettype wire

FILE: design/pcil_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pcil_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module pcil_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule : pcil_ram
`default_nettype wire

FILE: design/pcil_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pcil_dpath
// Tables, cursors, counts, config registers and result registers.
// ---------------------------------------------------------------------------
module pcil_dpath #(
    parameter int SPEED_DEPTH   = 16,
    parameter int HEADING_DEPTH = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire pcil_pkg::t_in_item                 i_in_item,
    input  wire logic                               i_cfg_we,
    input  wire logic [pcil_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [pcil_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    input  wire pcil_pkg::t_cmd                     i_cmd,
    output pcil_pkg::t_status                       o_status,
    output pcil_pkg::t_out_item                     o_out_item
);
    import pcil_pkg::*;

    localparam int SAW = (SPEED_DEPTH > 1) ? $clog2(SPEED_DEPTH) : 1;
    localparam int SCW = $clog2(SPEED_DEPTH + 1);
    localparam int HAW = (HEADING_DEPTH > 1) ? $clog2(HEADING_DEPTH) : 1;
    localparam int HCW = $clog2(HEADING_DEPTH + 1);

    t_in_item  r_item;
    t_out_item r_res;
    t_out_item r_out;

    logic             r_path_ready;
    logic [GAP_W-1:0] r_min_gap;

    logic [SCW-1:0]          r_spd_cnt;
    logic [SAW-1:0]          r_spd_cur;
    logic signed [POS_W-1:0] r_spd_last;
    logic [HCW-1:0]          r_hdg_cnt;
    logic [HAW-1:0]          r_hdg_cur;
    logic signed [POS_W-1:0] r_hdg_last;
    logic signed [POS_W-1:0] r_right;

    logic [SAW-1:0] w_spd_raddr;
    logic [HAW-1:0] w_hdg_raddr;
    t_spd_ent       w_spd_rdata;
    t_hdg_ent       w_hdg_rdata;
    t_spd_ent       w_spd_wdata;
    t_hdg_ent       w_hdg_wdata;
    logic           w_spd_we;
    logic           w_hdg_we;

    logic signed [POS_W:0]   w_spd_diff;
    logic signed [POS_W:0]   w_hdg_diff;
    logic signed [POS_W:0]   w_gap;
    logic                    w_spd_ok;
    logic                    w_hdg_ok;
    logic signed [POS_W-1:0] w_sel_pos;

    // insert check: table not full, step positive and at least min_gap (first entry exempt)
    assign w_gap      = $signed({{(POS_W + 1 - GAP_W){1'b0}}, r_min_gap});
    assign w_spd_diff = {r_item.position[POS_W-1], r_item.position}
                      - {r_spd_last[POS_W-1], r_spd_last};
    assign w_hdg_diff = {r_item.position[POS_W-1], r_item.position}
                      - {r_hdg_last[POS_W-1], r_hdg_last};
    assign w_spd_ok = (r_spd_cnt < SCW'(SPEED_DEPTH))
                   && ((r_spd_cnt == '0) || ((w_spd_diff > '0) && (w_spd_diff >= w_gap)));
    assign w_hdg_ok = (r_hdg_cnt < HCW'(HEADING_DEPTH))
                   && ((r_hdg_cnt == '0) || ((w_hdg_diff > '0) && (w_hdg_diff >= w_gap)));

    assign w_spd_we = i_cmd.ins && !i_cmd.tbl && w_spd_ok;
    assign w_hdg_we = i_cmd.ins &&  i_cmd.tbl && w_hdg_ok;

    assign w_spd_wdata = '{pos: r_item.position, speed: r_item.speed_limit,
                           accel: r_item.accel_limit, jerk: r_item.jerk_limit};
    assign w_hdg_wdata = '{pos: r_item.position, heading: r_item.heading,
                           turn_rate: r_item.turn_rate_limit,
                           turn_accel: r_item.turn_accel_limit,
                           tangent: r_item.tangent_heading};

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_DEC: begin
                w_spd_raddr = r_spd_cur - 1'b1;
                w_hdg_raddr = r_hdg_cur - 1'b1;
            end
            RD_INC: begin
                w_spd_raddr = r_spd_cur + 1'b1;
                w_hdg_raddr = r_hdg_cur + 1'b1;
            end
            default: begin
                w_spd_raddr = r_spd_cur;
                w_hdg_raddr = r_hdg_cur;
            end
        endcase
    end

    pcil_ram #(
        .WIDTH ($bits(t_spd_ent)),
        .DEPTH (SPEED_DEPTH)
    ) u_spd_ram (
        .i_clk   (i_clk),
        .i_we    (w_spd_we),
        .i_waddr (r_spd_cnt[SAW-1:0]),
        .i_wdata (w_spd_wdata),
        .i_raddr (w_spd_raddr),
        .o_rdata (w_spd_rdata)
    );

    pcil_ram #(
        .WIDTH ($bits(t_hdg_ent)),
        .DEPTH (HEADING_DEPTH)
    ) u_hdg_ram (
        .i_clk   (i_clk),
        .i_we    (w_hdg_we),
        .i_waddr (r_hdg_cnt[HAW-1:0]),
        .i_wdata (w_hdg_wdata),
        .i_raddr (w_hdg_raddr),
        .o_rdata (w_hdg_rdata)
    );

    assign w_sel_pos = i_cmd.tbl ? w_hdg_rdata.pos : w_spd_rdata.pos;

    always_comb begin
        o_status.req        = t_req'(r_item.req_type);
        o_status.path_ready = r_path_ready;
        o_status.empty      = i_cmd.tbl ? (r_hdg_cnt == '0) : (r_spd_cnt == '0);
        o_status.at_first   = i_cmd.tbl ? (r_hdg_cur == '0) : (r_spd_cur == '0);
        o_status.at_last    = i_cmd.tbl ? ((HCW'(r_hdg_cur) + 1'b1) == r_hdg_cnt)
                                        : ((SCW'(r_spd_cur) + 1'b1) == r_spd_cnt);
        o_status.gt         = r_item.position > w_sel_pos;
        o_status.lt         = r_item.position < w_sel_pos;
        o_status.gt_right   = r_item.position > r_right;
        o_status.neg        = r_item.position[POS_W-1];
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_ready <= 1'b0;
            r_min_gap    <= GAP_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_PATH_READY) begin
                r_path_ready <= i_cfg_data[0];
            end else if (i_cfg_index == CFG_MIN_GAP) begin
                r_min_gap <= i_cfg_data[GAP_W-1:0];
            end
        end
    end

    // counts and cursors
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spd_cnt <= '0;
            r_spd_cur <= '0;
            r_hdg_cnt <= '0;
            r_hdg_cur <= '0;
        end else if (i_cmd.clr) begin
            r_spd_cnt <= '0;
            r_spd_cur <= '0;
            r_hdg_cnt <= '0;
            r_hdg_cur <= '0;
        end else begin
            if (w_spd_we) begin
                r_spd_cnt <= r_spd_cnt + 1'b1;
            end
            if (w_hdg_we) begin
                r_hdg_cnt <= r_hdg_cnt + 1'b1;
            end
            if (!i_cmd.tbl) begin
                unique case (i_cmd.cur_op)
                    CUR_DEC: r_spd_cur <= r_spd_cur - 1'b1;
                    CUR_INC: r_spd_cur <= r_spd_cur + 1'b1;
                    CUR_CLAMP: begin
                        if ((r_spd_cnt != '0) && (SCW'(r_spd_cur) >= r_spd_cnt)) begin
                            r_spd_cur <= SAW'(r_spd_cnt - 1'b1);
                        end
                    end
                    default: r_spd_cur <= r_spd_cur;
                endcase
            end else begin
                unique case (i_cmd.cur_op)
                    CUR_DEC: r_hdg_cur <= r_hdg_cur - 1'b1;
                    CUR_INC: r_hdg_cur <= r_hdg_cur + 1'b1;
                    CUR_CLAMP: begin
                        if ((r_hdg_cnt != '0) && (HCW'(r_hdg_cur) >= r_hdg_cnt)) begin
                            r_hdg_cur <= HAW'(r_hdg_cnt - 1'b1);
                        end
                    end
                    default: r_hdg_cur <= r_hdg_cur;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_item;
            r_res  <= '0;
        end
        if (w_spd_we) begin
            r_spd_last <= r_item.position;
        end
        if (w_hdg_we) begin
            r_hdg_last <= r_item.position;
        end
        // right bound is the cursor entry, saved while the left-neighbour read is issued
        if (i_cmd.rd_sel == RD_DEC) begin
            r_right <= w_sel_pos;
        end
        if (i_cmd.ins) begin
            r_res.accepted <= i_cmd.tbl ? w_hdg_ok : w_spd_ok;
        end
        if (i_cmd.clr) begin
            r_res.accepted <= 1'b1;
        end
        if (i_cmd.cap) begin
            if (i_cmd.tbl) begin
                r_res.heading_valid  <= 1'b1;
                r_res.out_heading    <= w_hdg_rdata.heading;
                r_res.out_turn_rate  <= w_hdg_rdata.turn_rate;
                r_res.out_turn_accel <= w_hdg_rdata.turn_accel;
                r_res.out_tangent    <= w_hdg_rdata.tangent;
            end else begin
                r_res.speed_valid <= 1'b1;
                r_res.out_speed   <= w_spd_rdata.speed;
                r_res.out_accel   <= w_spd_rdata.accel;
                r_res.out_jerk    <= w_spd_rdata.jerk;
            end
        end
        if (i_cmd.ld_out) begin
            r_out <= r_res;
        end
    end

    assign o_out_item = r_out;

    // cursor always inside a non-empty table, zero for an empty one
    logic w_spd_cur_ok;
    logic w_hdg_cur_ok;
    assign w_spd_cur_ok = (r_spd_cnt == '0) ? (r_spd_cur == '0)
                                            : (SCW'(r_spd_cur) < r_spd_cnt);
    assign w_hdg_cur_ok = (r_hdg_cnt == '0) ? (r_hdg_cur == '0)
                                            : (HCW'(r_hdg_cur) < r_hdg_cnt);

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_spd_cur_ok && w_hdg_cur_ok)
        else $error("cursor outside its table");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_spd_cnt <= SCW'(SPEED_DEPTH)) && (r_hdg_cnt <= HCW'(HEADING_DEPTH)))
        else $error("table count beyond depth");

    a_refused_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.ins && !i_cmd.tbl && !w_spd_ok) |=> $stable(r_spd_cnt))
        else $error("refused speed insert changed the count");

endmodule : pcil_dpath
`default_nettype wire

FILE: design/pcil_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pcil_ctrl
// Sequencer: dispatches requests and walks the table cursors.
// ---------------------------------------------------------------------------
module pcil_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    output logic                   o_valid,
    input  wire logic              i_stall,
    input  wire pcil_pkg::t_status i_status,
    output pcil_pkg::t_cmd         o_cmd
);
    import pcil_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_EXEC  = 13'b0000000000010,
        S_CLAMP = 13'b0000000000100,
        S_RD_R  = 13'b0000000001000,
        S_CHK_R = 13'b0000000010000,
        S_CHK_L = 13'b0000000100000,
        S_STEPL = 13'b0000001000000,
        S_WALKL = 13'b0000010000000,
        S_STEPR = 13'b0000100000000,
        S_WALKR = 13'b0001000000000,
        S_FETCH = 13'b0010000000000,
        S_CAP   = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_tbl, n_tbl;
    logic   r_ov, n_ov;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ov;

    always_comb begin
        n_state       = r_state;
        n_tbl         = r_tbl;
        o_cmd.tbl     = r_tbl;
        o_cmd.rd_sel  = RD_CUR;
        o_cmd.cur_op  = CUR_HOLD;
        o_cmd.load    = 1'b0;
        o_cmd.ins     = 1'b0;
        o_cmd.clr     = 1'b0;
        o_cmd.cap     = 1'b0;
        o_cmd.ld_out  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_status.req)
                    REQ_INS_SPD: begin
                        o_cmd.tbl = 1'b0;
                        o_cmd.ins = 1'b1;
                        n_state   = S_DONE;
                    end
                    REQ_INS_HDG: begin
                        o_cmd.tbl = 1'b1;
                        o_cmd.ins = 1'b1;
                        n_state   = S_DONE;
                    end
                    REQ_CLEAR: begin
                        o_cmd.clr = 1'b1;
                        n_state   = S_DONE;
                    end
                    default: begin   // query
                        n_tbl   = 1'b0;
                        n_state = i_status.path_ready ? S_CLAMP : S_DONE;
                    end
                endcase
            end
            S_CLAMP: begin
                if (i_status.empty) begin
                    n_tbl   = 1'b1;
                    n_state = r_tbl ? S_DONE : S_CLAMP;
                end else begin
                    o_cmd.cur_op = CUR_CLAMP;
                    n_state      = S_RD_R;
                end
            end
            S_RD_R: begin
                n_state = S_CHK_R;
            end
            S_CHK_R: begin
                // data is the right bound of the cursor interval
                if (i_status.at_first) begin
                    // first interval starts at zero: below it the cursor stays
                    n_state = (i_status.gt && !i_status.neg) ? S_STEPR : S_FETCH;
                end else begin
                    o_cmd.rd_sel = RD_DEC;
                    n_state      = S_CHK_L;
                end
            end
            S_CHK_L: begin
                // data is the left bound
                if (i_status.lt) begin
                    o_cmd.cur_op = CUR_DEC;
                    n_state      = S_STEPL;
                end else if (i_status.gt_right) begin
                    n_state = S_STEPR;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_STEPL: begin
                if (i_status.at_first) begin
                    n_state = S_FETCH;
                end else begin
                    o_cmd.rd_sel = RD_DEC;
                    n_state      = S_WALKL;
                end
            end
            S_WALKL: begin
                if (i_status.gt) begin
                    n_state = S_FETCH;
                end else begin
                    o_cmd.cur_op = CUR_DEC;
                    n_state      = S_STEPL;
                end
            end
            S_STEPR: begin
                if (i_status.at_last) begin
                    n_state = S_FETCH;
                end else begin
                    o_cmd.rd_sel = RD_INC;
                    o_cmd.cur_op = CUR_INC;
                    n_state      = S_WALKR;
                end
            end
            S_WALKR: begin
                n_state = i_status.gt ? S_STEPR : S_FETCH;
            end
            S_FETCH: begin
                n_state = S_CAP;
            end
            S_CAP: begin
                o_cmd.cap = 1'b1;
                n_tbl     = 1'b1;
                n_state   = r_tbl ? S_DONE : S_CLAMP;
            end
            S_DONE: begin
                if (!r_ov || !i_stall) begin
                    o_cmd.ld_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ov = r_ov && i_stall;
        if (o_cmd.ld_out) begin
            n_ov = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tbl   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tbl   <= n_tbl;
            r_ov    <= n_ov;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_stall) |-> !o_cmd.ld_out)
        else $error("output register overwritten while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken again before result built");

    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == S_DONE))
        else $error("result presented outside the done step");

endmodule : pcil_ctrl
`default_nettype wire
